// ----- rtl/core/scpr_pkg.sv -----
// Shared types and constants for the second-chance page replacement unit.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none

package scpr_pkg;

	localparam int PAGE_W  = 16;  // page_number / evicted_page word width
	localparam int FRAME_W = 3;   // frame_index width
	localparam int FIU_W   = 4;   // frames_in_use register width
	localparam int FAULT_W = 16;  // fault_count width

	localparam int DEF_NUM_FRAMES = 8;
	localparam int DEF_PAGE_BITS  = 16;

	localparam logic [FIU_W-1:0]   FIU_RESET = 4'd8;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_SWEEP
	} state_t;

	// Controller to datapath commands, at most one per cycle.
	typedef struct packed {
		logic load;         // capture the accepted page
		logic lookup;       // compare against all active frames
		logic hit_commit;   // set reference bit, post hit result
		logic sweep_start;  // wrap the hand if it is out of range
		logic sweep_step;   // clear reference bit under hand, advance
		logic fill_commit;  // refill frame under hand, post fault result
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic any_match;    // lookup found the page
		logic hand_busy;    // frame under hand is valid with its bit set
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/scpr_req_if.sv -----
// Request channel: one page reference per word, valid/ready handshake.
// Depends on scpr_pkg for the payload width.
`default_nettype none

interface scpr_req_if;
	logic                       valid;
	logic                       ready;
	logic [scpr_pkg::PAGE_W-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/scpr_rsp_if.sv -----
// Result channel: one lookup/replacement outcome per word, valid/ready handshake.
// Depends on scpr_pkg for the payload widths.
`default_nettype none

interface scpr_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [scpr_pkg::FRAME_W-1:0] frame_index;
	logic                         evicted_valid;
	logic [scpr_pkg::PAGE_W-1:0]  evicted_page;
	logic [scpr_pkg::FAULT_W-1:0] fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/scpr_ctrl.sv -----
// Controller state machine: sequences accept, lookup, decide and sweep/fill.
// Depends on scpr_pkg for state_t, cmd_t and sts_t; drives the datapath by command.
`default_nettype none

module scpr_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  scpr_pkg::sts_t   sts,
	output scpr_pkg::cmd_t   cmd
);

	scpr_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scpr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.hit_commit || cmd.fill_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			scpr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = scpr_pkg::ST_LOOKUP;
				end
			end
			scpr_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = scpr_pkg::ST_DECIDE;
			end
			scpr_pkg::ST_DECIDE: begin
				if (sts.any_match) begin
					// hold until the result register can take the word
					if (out_free) begin
						cmd.hit_commit = 1'b1;
						state_d        = scpr_pkg::ST_IDLE;
					end
				end else begin
					cmd.sweep_start = 1'b1;
					state_d         = scpr_pkg::ST_SWEEP;
				end
			end
			scpr_pkg::ST_SWEEP: begin
				if (sts.hand_busy) begin
					cmd.sweep_step = 1'b1;
				end else if (out_free) begin
					cmd.fill_commit = 1'b1;
					state_d         = scpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scpr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/scpr_datapath.sv -----
// Datapath: frame table, parallel page compare, clock hand, fault counter,
// frames_in_use register and result register. Depends on scpr_pkg.
`default_nettype none

module scpr_datapath #(
	parameter int NUM_FRAMES = scpr_pkg::DEF_NUM_FRAMES,
	parameter int PAGE_BITS  = scpr_pkg::DEF_PAGE_BITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [scpr_pkg::FIU_W-1:0]    cfg_wr_data,
	input  wire [scpr_pkg::PAGE_W-1:0]   page_number,
	input  scpr_pkg::cmd_t               cmd,
	output scpr_pkg::sts_t               sts,
	output logic                         res_hit,
	output logic [scpr_pkg::FRAME_W-1:0] res_frame,
	output logic                         res_ev_valid,
	output logic [scpr_pkg::PAGE_W-1:0]  res_ev_page,
	output logic [scpr_pkg::FAULT_W-1:0] res_fault
);

	localparam int STORE_W = (PAGE_BITS < scpr_pkg::PAGE_W) ? PAGE_BITS : scpr_pkg::PAGE_W;
	localparam int IW      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int AW      = IW + 1;
	localparam int MW      = (AW > scpr_pkg::FIU_W) ? AW : scpr_pkg::FIU_W;

	logic [STORE_W-1:0]           page_tbl_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]        valid_q;
	logic [NUM_FRAMES-1:0]        ref_q;
	logic [NUM_FRAMES-1:0]        match_q;
	logic [IW-1:0]                hand_q;
	logic [scpr_pkg::FAULT_W-1:0] fault_q;
	logic [scpr_pkg::FIU_W-1:0]   fiu_q;
	logic [STORE_W-1:0]           page_q;

	logic [MW-1:0]                fiu_w;
	logic [AW-1:0]                n_eff;
	logic [IW-1:0]                first_idx;
	logic [IW-1:0]                hand_adv;
	logic [AW-1:0]                hand_inc;
	logic [scpr_pkg::FAULT_W-1:0] fault_inc;
	logic [IW+2:0]                first_wide;
	logic [IW+2:0]                hand_wide;

	// Clamp frames_in_use to 1..NUM_FRAMES.
	always_comb begin
		fiu_w = MW'(fiu_q);
		if (fiu_w == '0) begin
			n_eff = AW'(1);
		end else if (fiu_w > MW'(NUM_FRAMES)) begin
			n_eff = AW'(NUM_FRAMES);
		end else begin
			n_eff = AW'(fiu_w);
		end
	end

	// Lowest-numbered match wins.
	always_comb begin
		first_idx = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				first_idx = IW'(i);
			end
		end
	end

	assign hand_inc  = AW'(hand_q) + AW'(1);
	assign hand_adv  = (hand_inc >= n_eff) ? '0 : hand_inc[IW-1:0];
	assign fault_inc = (fault_q == scpr_pkg::FAULT_MAX) ? fault_q : fault_q + 1'b1;
	assign first_wide = (IW+3)'(first_idx);
	assign hand_wide  = (IW+3)'(hand_q);

	assign sts.any_match = |match_q;
	assign sts.hand_busy = valid_q[hand_q] && ref_q[hand_q];

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
			hand_q  <= '0;
			fault_q <= '0;
			fiu_q   <= scpr_pkg::FIU_RESET;
		end else begin
			if (cfg_wr_en) begin
				fiu_q <= cfg_wr_data;
			end
			if (cmd.hit_commit) begin
				ref_q[first_idx] <= 1'b1;
			end
			if (cmd.sweep_start && (AW'(hand_q) >= n_eff)) begin
				hand_q <= '0;
			end
			if (cmd.sweep_step) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_adv;
			end
			if (cmd.fill_commit) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b0;
				hand_q          <= hand_adv;
				fault_q         <= fault_inc;
			end
		end
	end

	// Payload: page table, compare vector and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_number[STORE_W-1:0];
		end
		if (cmd.lookup) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				match_q[i] <= valid_q[i] && (page_tbl_q[i] == page_q) && (AW'(i) < n_eff);
			end
		end
		if (cmd.hit_commit) begin
			res_hit      <= 1'b1;
			res_frame    <= first_wide[scpr_pkg::FRAME_W-1:0];
			res_ev_valid <= 1'b0;
			res_ev_page  <= '0;
			res_fault    <= fault_q;
		end
		if (cmd.fill_commit) begin
			page_tbl_q[hand_q] <= page_q;
			res_hit      <= 1'b0;
			res_frame    <= hand_wide[scpr_pkg::FRAME_W-1:0];
			res_ev_valid <= valid_q[hand_q];
			res_ev_page  <= valid_q[hand_q] ? scpr_pkg::PAGE_W'(page_tbl_q[hand_q]) : '0;
			res_fault    <= fault_inc;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/second_chance_page_replacement_unit.sv -----
// Top level of the second-chance (clock) page replacement unit.
// Depends on scpr_pkg, scpr_req_if, scpr_rsp_if, scpr_ctrl and scpr_datapath.
//
// Each request word carries one page reference; each produces exactly one result word.
// The page is compared in parallel against all active valid frames (the first
// frames_in_use frames, clamped to 1..NUM_FRAMES). On a hit the lowest matching frame gets
// its reference bit set and nothing else changes. On a miss the clock hand sweeps one
// frame per cycle, clearing set reference bits, until it reaches an empty frame or one
// with a clear bit; that frame is refilled, the hand advances past it and the saturating
// fault count is bumped. One item is in work at a time: a hit passes through accept, compare
// and decide before its result is registered; a miss passes through accept, compare and
// decide, then the sweep of the clock hand and the refill that registers its result.
// A hit or a refill waits while an earlier result still waits unaccepted in the result
// register. The result register frees the request side: the next word is taken while
// a finished result still waits on the result channel.
// Write frames_in_use only while the unit is idle. The page table has no reset; frame
// valid bits, reference bits, hand and fault count clear on reset.
`default_nettype none

module second_chance_page_replacement_unit #(
	parameter int NUM_FRAMES = scpr_pkg::DEF_NUM_FRAMES,
	parameter int PAGE_BITS  = scpr_pkg::DEF_PAGE_BITS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire [scpr_pkg::FIU_W-1:0]  cfg_wr_data,
	scpr_req_if.sink                   req,
	scpr_rsp_if.source                 rsp
);

	scpr_pkg::cmd_t cmd;
	scpr_pkg::sts_t sts;

	// Sequence each word: accept, compare, then hit or sweep.
	scpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Frame table, hand, counters and the result register.
	scpr_datapath #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.page_number  (req.page_number),
		.cmd          (cmd),
		.sts          (sts),
		.res_hit      (rsp.hit),
		.res_frame    (rsp.frame_index),
		.res_ev_valid (rsp.evicted_valid),
		.res_ev_page  (rsp.evicted_page),
		.res_fault    (rsp.fault_count)
	);

	// At most one command per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.lookup, cmd.hit_commit, cmd.sweep_start,
			cmd.sweep_step, cmd.fill_commit}))
		else $error("controller issued more than one command");

	// A captured page is always compared on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.lookup)
		else $error("lookup did not follow load");

	// Refill only a frame that the sweep may take.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_commit |-> !sts.hand_busy)
		else $error("refill of a frame with its reference bit set");

	// A posted result shows up on the result channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hit_commit || cmd.fill_commit) |=> rsp.valid)
		else $error("result word lost");

	// No request is taken while a miss is still being swept.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_start || cmd.sweep_step) |-> !req.ready)
		else $error("request accepted during sweep");

endmodule

`default_nettype wire
